@@ hdl/aeg_pkg.sv @@
// Shared types, widths and codes of the ADSR envelope generator.
package aeg_pkg;

    // Data path sizing
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int COUNT_WIDTH    = 32;

    localparam int GAIN_W   = GAIN_FRAC_BITS + 1;
    localparam int RATE_W   = 18;
    localparam int TIME_W   = 16;
    localparam int SUS_W    = 17;
    localparam int SCMP_W   = (SUS_W > GAIN_W) ? SUS_W : GAIN_W;

    // Milliseconds scale factor and its width
    localparam int K_MS     = 1000;
    localparam int K_MS_W   = 10;

    localparam int NUM_W    = COUNT_WIDTH + K_MS_W;
    localparam int DEN_W    = TIME_W + RATE_W;
    localparam int CMP_W    = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int ACC_W    = GAIN_W + NUM_W;
    localparam int REM_W    = DEN_W + 1;
    localparam int STEP_W   = $clog2(GAIN_W);
    localparam int PROD_W   = SAMPLE_WIDTH + GAIN_W + 1;

    // Stream payload widths
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + GAIN_W + 7) / 8) * 8;
    localparam int CMD_W       = 2;
    localparam int PHASE_W     = 3;

    // Register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RATE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

    localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(48000);
    localparam logic [SUS_W-1:0]  SUSTAIN_RESET = SUS_W'(GAIN_ONE);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] attack;
        logic [TIME_W-1:0] decay;
        logic [SUS_W-1:0]  sustain;
        logic [TIME_W-1:0] rel_len;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic eval;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic gain_load;
        logic scale;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_sample;
        logic need_ramp;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/aeg_ctrl.sv @@
// Sequencer for the envelope: steps the datapath through scale, multiply and divide.
module aeg_ctrl import aeg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_EVAL  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_DLOAD = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_GAIN  = 9'b001000000,
        ST_SCALE = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAIN_W - 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.in_sample) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.need_ramp) begin
                    n_state = ST_MUL;
                    n_step  = STEP_LAST;
                end else begin
                    n_state = ST_SCALE;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DLOAD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = STEP_LAST;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_GAIN;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_GAIN: begin
                o_cmd.gain_load = 1'b1;
                n_state         = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ hdl/aeg_dp.sv @@
// Envelope datapath: phase state, counter, shift-add ramp multiply, restoring divide, scaling.
module aeg_dp import aeg_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  t_cfg                       i_cfg,
    input  logic [CMD_W-1:0]           i_in_command,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_sample,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]    o_out_sample,
    output logic [GAIN_W-1:0]          o_out_gain,
    output logic [PHASE_W-1:0]         o_out_phase
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Envelope state
    t_phase                         r_phase;
    logic [COUNT_WIDTH-1:0]         r_count;
    logic [GAIN_W-1:0]              r_last_gain;
    logic [GAIN_W-1:0]              r_rsg;

    // Working registers
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic [NUM_W-1:0]               r_num;
    logic [DEN_W-1:0]               r_den;
    logic [GAIN_W-1:0]              r_span;
    logic [GAIN_W-1:0]              r_base;
    logic                           r_sub;
    logic [ACC_W-1:0]               r_acc;
    logic [DEN_W-1:0]               r_rem;
    logic [GAIN_W-1:0]              r_gain;
    logic signed [PROD_W-1:0]       r_prod;
    t_phase                         r_eval_phase;

    // Output register
    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_sample;
    logic [GAIN_W-1:0]              r_out_gain;
    t_phase                         r_out_phase;

    logic [TIME_W-1:0]              w_time;
    logic [RATE_W-1:0]              w_fs;
    logic [GAIN_W-1:0]              w_sus;
    logic [GAIN_W-1:0]              w_r0;
    logic                           w_ge;
    logic                           w_ramp_phase;
    logic                           w_need_ramp;
    logic                           w_end;
    t_phase                         w_next_phase;
    logic [GAIN_W-1:0]              w_direct;
    logic [GAIN_W-1:0]              w_span;
    logic [GAIN_W-1:0]              w_base;
    logic                           w_sub;
    logic [ACC_W-1:0]               w_addend;
    logic [CMP_W-1:0]               w_hi;
    logic [REM_W-1:0]               w_trial;
    logic                           w_fit;
    logic [GAIN_W-1:0]              w_q;
    logic [GAIN_W-1:0]              w_ramp;
    logic [GAIN_W-1:0]              w_ramp_gain;

    // Segment length and clamped levels
    always_comb begin
        unique case (r_phase)
            PH_ATTACK:  w_time = i_cfg.attack;
            PH_DECAY:   w_time = i_cfg.decay;
            PH_RELEASE: w_time = i_cfg.rel_len;
            default:    w_time = '0;
        endcase
    end

    assign w_fs  = (i_cfg.rate == '0) ? RATE_W'(1) : i_cfg.rate;
    assign w_sus = (SCMP_W'(i_cfg.sustain) > SCMP_W'(GAIN_ONE)) ? GAIN_ONE
                                                               : GAIN_W'(i_cfg.sustain);
    assign w_r0  = (r_rsg > GAIN_ONE) ? GAIN_ONE : r_rsg;
    assign w_ge  = CMP_W'(r_num) >= CMP_W'(r_den);

    // Decide end of segment, direct gain and ramp operands
    always_comb begin
        w_ramp_phase = 1'b0;
        w_next_phase = r_phase;
        w_direct     = '0;
        w_span       = '0;
        w_base       = '0;
        w_sub        = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                w_direct = GAIN_ONE;
            end
            PH_ATTACK: begin
                w_ramp_phase = 1'b1;
                w_direct     = GAIN_ONE;
                w_next_phase = PH_DECAY;
                w_span       = GAIN_ONE;
            end
            PH_DECAY: begin
                w_ramp_phase = 1'b1;
                w_direct     = w_sus;
                w_next_phase = PH_SUSTAIN;
                w_span       = GAIN_ONE - w_sus;
                w_base       = GAIN_ONE;
                w_sub        = 1'b1;
            end
            PH_SUSTAIN: begin
                w_direct = w_sus;
            end
            PH_RELEASE: begin
                w_ramp_phase = 1'b1;
                w_direct     = '0;
                w_next_phase = PH_IDLE;
                w_span       = w_r0;
                w_base       = w_r0;
                w_sub        = 1'b1;
            end
            default: begin
                w_direct = '0;
            end
        endcase
    end

    assign w_need_ramp = w_ramp_phase && !w_ge;
    assign w_end       = w_ramp_phase && w_ge;

    // Shift-add step, divide step and final ramp level
    assign w_addend    = r_span[GAIN_W-1] ? ACC_W'(r_num) : '0;
    assign w_hi        = CMP_W'(r_acc[ACC_W-1:GAIN_W]);
    assign w_trial     = {r_rem, r_acc[GAIN_W-1]};
    assign w_fit       = w_trial >= REM_W'(r_den);
    assign w_q         = r_acc[GAIN_W-1:0];
    assign w_ramp      = r_sub ? (r_base - w_q) : w_q;
    assign w_ramp_gain = (w_ramp > GAIN_ONE) ? GAIN_ONE : w_ramp;

    // Envelope state: commands, segment ends, level history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_last_gain <= '0;
            r_rsg       <= '0;
        end else if (i_cmd.accept) begin
            case (i_in_command)
                CMD_SAMPLE: begin
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                CMD_TRIGGER: begin
                    r_phase <= PH_ATTACK;
                    r_count <= '0;
                end
                CMD_RELEASE: begin
                    r_rsg   <= r_last_gain;
                    r_phase <= PH_RELEASE;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.eval) begin
            if (!w_need_ramp) begin
                r_last_gain <= w_direct;
            end
            if (w_end) begin
                r_phase <= w_next_phase;
                r_count <= '0;
            end
        end else if (i_cmd.gain_load) begin
            r_last_gain <= w_ramp_gain;
        end
    end

    // Working registers of one sample request
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_in_sample;
        end
        if (i_cmd.prep) begin
            r_num <= NUM_W'(r_count) * NUM_W'(K_MS);
            r_den <= DEN_W'(w_time) * DEN_W'(w_fs);
        end
        if (i_cmd.eval) begin
            r_eval_phase <= r_phase;
            r_span       <= w_span;
            r_base       <= w_base;
            r_sub        <= w_sub;
            r_acc        <= '0;
            if (!w_need_ramp) begin
                r_gain <= w_direct;
            end
        end else if (i_cmd.mul_step) begin
            r_acc  <= {r_acc[ACC_W-2:0], 1'b0} + w_addend;
            r_span <= {r_span[GAIN_W-2:0], 1'b0};
        end else if (i_cmd.div_load) begin
            r_rem <= w_hi[DEN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem              <= w_fit ? DEN_W'(w_trial - REM_W'(r_den)) : w_trial[DEN_W-1:0];
            r_acc[GAIN_W-1:0]  <= {r_acc[GAIN_W-2:0], w_fit};
        end else if (i_cmd.gain_load) begin
            r_gain <= w_ramp_gain;
        end
        if (i_cmd.scale) begin
            r_prod <= r_sample * $signed({1'b0, r_gain});
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: floor of product over unity, truncated to sample width
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= r_prod[GAIN_FRAC_BITS +: SAMPLE_WIDTH];
            r_out_gain   <= r_gain;
            r_out_phase  <= r_eval_phase;
        end
    end

    assign o_stat.in_sample = (i_in_command == CMD_SAMPLE);
    assign o_stat.need_ramp = w_need_ramp;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_gain   = r_out_gain;
    assign o_out_phase  = r_out_phase;

endmodule

@@ hdl/adsr_envelope_generator_core.sv @@
// Top level of the linear ADSR envelope generator: register port, sequencer and datapath.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         tvalid/tready             tdata: sample_in; tuser: command
//  m_axis    out        tvalid/tready             tdata: sample_out, gain; tuser: phase
//  apb       in/out     psel/penable, pready = 1  five envelope registers
//
// A trigger, release or unused command is taken in idle and leaves the sequencer idle.
// An audio sample runs prep, evaluate, scale and output when no ramp is running (idle,
// sustain, segment end); a ramp adds shift-add multiply, restoring divide and gain load.
// Reset is synchronous, active low, and returns the envelope to idle with a zero counter.
// A finished result waits in the output register; the next request is taken meanwhile and
// holds only at its last step if the previous result is still not taken.
module adsr_envelope_generator_core import aeg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample_in [15:0]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]       s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_out [15:0], gain [32:16], zero fill [39:33]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // phase [2:0]
    output logic [PHASE_W-1:0]     m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    t_cfg                    r_cfg;
    t_dp_cmd                 w_cmd;
    t_dp_stat                w_stat;
    logic [REG_IDX_W-1:0]    w_idx;
    logic [SAMPLE_WIDTH-1:0] w_out_sample;
    logic [GAIN_W-1:0]       w_out_gain;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    // Write envelope registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate    <= RATE_RESET;
            r_cfg.attack  <= '0;
            r_cfg.decay   <= '0;
            r_cfg.sustain <= SUSTAIN_RESET;
            r_cfg.rel_len <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_RATE:    r_cfg.rate    <= pwdata[RATE_W-1:0];
                REG_ATTACK:  r_cfg.attack  <= pwdata[TIME_W-1:0];
                REG_DECAY:   r_cfg.decay   <= pwdata[TIME_W-1:0];
                REG_SUSTAIN: r_cfg.sustain <= pwdata[SUS_W-1:0];
                REG_RELEASE: r_cfg.rel_len <= pwdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back envelope registers
    always_comb begin
        unique case (w_idx)
            REG_RATE:    prdata = PDATA_W'(r_cfg.rate);
            REG_ATTACK:  prdata = PDATA_W'(r_cfg.attack);
            REG_DECAY:   prdata = PDATA_W'(r_cfg.decay);
            REG_SUSTAIN: prdata = PDATA_W'(r_cfg.sustain);
            REG_RELEASE: prdata = PDATA_W'(r_cfg.rel_len);
            default:     prdata = '0;
        endcase
    end

    aeg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aeg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg        (r_cfg),
        .i_in_command (s_axis_tuser),
        .i_in_sample  ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_sample (w_out_sample),
        .o_out_gain   (w_out_gain),
        .o_out_phase  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_out_gain, w_out_sample});

endmodule

@@ hdl/aeg_checker.sv @@
// Port-level checks of the envelope generator, bound to the top level.
module aeg_checker import aeg_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic [CMD_W-1:0]       s_axis_tuser,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [PHASE_W-1:0]     m_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    logic [GAIN_W-1:0]       w_gain;
    logic [SAMPLE_WIDTH-1:0] w_sample;

    assign w_gain   = m_axis_tdata[SAMPLE_WIDTH +: GAIN_W];
    assign w_sample = m_axis_tdata[SAMPLE_WIDTH-1:0];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Gain never above unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_gain <= GAIN_ONE)
        else $error("gain above unity");

    // Idle passes audio at unity gain
    a_idle_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == PH_IDLE) |-> w_gain == GAIN_ONE)
        else $error("idle gain not unity");

    // Zero gain silences the sample
    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_gain == '0) |-> w_sample == '0)
        else $error("nonzero output at zero gain");

    // Trigger and release requests produce no result
    a_cmd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_SAMPLE) && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result from non-sample request");

endmodule

bind adsr_envelope_generator_core aeg_checker u_aeg_checker (.*);
